// ----- rtl/core/lkhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkhp_pkg
// Shared types, constants and helpers for the line key hash partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

package lkhp_pkg;

  // field widths
  localparam int unsigned HASH_W = 32;
  localparam int unsigned BKT_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 5;

  // fnv-1a offset basis
  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

  // prime 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0, so the product is
  // the operand itself plus five shifted copies, one add per step
  localparam int unsigned MUL_STEPS = 5;
  localparam int unsigned DIV_STEPS = HASH_W;

  // special text bytes
  localparam logic [BYTE_W-1:0] BYTE_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;

  // register index of the bucket count
  localparam logic REG_BUCKET_COUNT = 1'b0;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  // request to the shared adder
  typedef struct packed {
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // shifted copy of the operand added in a given multiply step
  function automatic logic [HASH_W-1:0] mul_term(input logic [HASH_W-1:0] x,
                                                 input logic [2:0] step);
    logic [HASH_W-1:0] r;
    case (step)
      3'd0:    r = x << 1;
      3'd1:    r = x << 4;
      3'd2:    r = x << 7;
      3'd3:    r = x << 8;
      default: r = x << 24;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lkhp_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkhp_alu
// Shared 32-bit add/subtract unit used by the multiply and remainder steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lkhp_alu (
  input  var lkhp_pkg::alu_req_t          req_i,
  output logic [lkhp_pkg::HASH_W:0]       sum_o
);

  logic [lkhp_pkg::HASH_W-1:0] b_eff;

  // invert b and carry in for subtract; sum_o msb is no-borrow there
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = {1'b0, req_i.a} + {1'b0, b_eff} +
                 {{lkhp_pkg::HASH_W{1'b0}}, req_i.sub};

endmodule

`default_nettype wire

// ----- rtl/core/lkhp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkhp_core
// Sequencer and datapath: hash folding, remainder loop and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkhp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lkhp_pkg::BKT_W-1:0]    bucket_count_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [lkhp_pkg::BYTE_W-1:0]   s_tdata_i,
  input  logic                          s_tlast_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [lkhp_pkg::BKT_W-1:0]    m_bucket_o,
  output logic [lkhp_pkg::HASH_W-1:0]   m_hash_o
);

  localparam int unsigned HW = lkhp_pkg::HASH_W;
  localparam int unsigned BW = lkhp_pkg::BKT_W;

  lkhp_pkg::state_e   state_q, state_d;
  lkhp_pkg::alu_req_t alu_req;
  logic [HW:0]        alu_sum;

  logic [HW-1:0]               hash_q;
  logic                        key_phase_q;
  logic [HW-1:0]               term_q;
  logic [HW-1:0]               dvd_q;
  logic [HW-1:0]               key_q;
  logic [BW-1:0]               rem_q;
  logic [lkhp_pkg::CNT_W-1:0]  cnt_q;
  logic                        m_valid_q;
  logic [BW-1:0]               m_bucket_q;
  logic [HW-1:0]               m_hash_q;

  logic        in_xfer;
  logic        line_end;
  logic        key_stop;
  logic        mul_last;
  logic        div_last;
  logic        out_free;
  logic [BW:0] div_t;
  logic [HW-1:0] folded;

  assign in_xfer  = s_tvalid_i && s_tready_o;
  assign line_end = s_tlast_i || (s_tdata_i == lkhp_pkg::BYTE_NEWLINE);
  assign key_stop = (s_tdata_i == lkhp_pkg::BYTE_TAB) ||
                    (s_tdata_i == lkhp_pkg::BYTE_NUL);
  assign mul_last = (cnt_q == lkhp_pkg::CNT_W'(lkhp_pkg::MUL_STEPS - 1));
  assign div_last = (cnt_q == lkhp_pkg::CNT_W'(lkhp_pkg::DIV_STEPS - 1));
  assign out_free = !m_valid_q || m_tready_i;
  assign div_t    = {rem_q, dvd_q[HW-1]};
  assign folded   = hash_q ^ {{(HW - lkhp_pkg::BYTE_W){1'b0}}, s_tdata_i};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkhp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (line_end) begin
            state_d = (bucket_count_i != '0) ? lkhp_pkg::ST_DIV : lkhp_pkg::ST_OUT;
          end else if (key_phase_q && !key_stop) begin
            state_d = lkhp_pkg::ST_MUL;
          end
        end
      end
      lkhp_pkg::ST_MUL: begin
        if (mul_last) state_d = lkhp_pkg::ST_IDLE;
      end
      lkhp_pkg::ST_DIV: begin
        if (div_last) state_d = lkhp_pkg::ST_OUT;
      end
      lkhp_pkg::ST_OUT: begin
        if (out_free) state_d = lkhp_pkg::ST_IDLE;
      end
      default: state_d = lkhp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: input ready and shared adder request
  always_comb begin
    s_tready_o  = 1'b0;
    alu_req.a   = hash_q;
    alu_req.b   = lkhp_pkg::mul_term(term_q, cnt_q[2:0]);
    alu_req.sub = 1'b0;
    unique case (state_q)
      lkhp_pkg::ST_IDLE: s_tready_o = 1'b1;
      lkhp_pkg::ST_MUL: begin
        alu_req.a   = hash_q;
        alu_req.b   = lkhp_pkg::mul_term(term_q, cnt_q[2:0]);
        alu_req.sub = 1'b0;
      end
      lkhp_pkg::ST_DIV: begin
        alu_req.a   = {{(HW - BW - 1){1'b0}}, div_t};
        alu_req.b   = {{(HW - BW){1'b0}}, bucket_count_i};
        alu_req.sub = 1'b1;
      end
      lkhp_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  lkhp_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkhp_pkg::ST_IDLE;
      hash_q      <= lkhp_pkg::FNV_BASIS;
      key_phase_q <= 1'b1;
      cnt_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        lkhp_pkg::ST_IDLE: begin
          cnt_q <= '0;
          if (in_xfer) begin
            if (line_end) begin
              hash_q      <= lkhp_pkg::FNV_BASIS;
              key_phase_q <= 1'b1;
            end else if (key_phase_q) begin
              if (key_stop) begin
                key_phase_q <= 1'b0;
              end else begin
                hash_q <= folded;
              end
            end
          end
        end
        lkhp_pkg::ST_MUL: begin
          hash_q <= alu_sum[HW-1:0];
          cnt_q  <= cnt_q + 1'b1;
        end
        lkhp_pkg::ST_DIV: cnt_q <= cnt_q + 1'b1;
        lkhp_pkg::ST_OUT: ;
        default: ;
      endcase
      // result register handshake
      if (state_q == lkhp_pkg::ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lkhp_pkg::ST_IDLE: begin
        term_q <= folded;
        dvd_q  <= hash_q;
        key_q  <= hash_q;
        rem_q  <= '0;
      end
      lkhp_pkg::ST_DIV: begin
        dvd_q <= dvd_q << 1;
        rem_q <= alu_sum[HW] ? alu_sum[BW-1:0] : div_t[BW-1:0];
      end
      lkhp_pkg::ST_OUT: begin
        if (out_free) begin
          m_bucket_q <= rem_q;
          m_hash_q   <= key_q;
        end
      end
      lkhp_pkg::ST_MUL: ;
      default: ;
    endcase
  end

  assign m_tvalid_o = m_valid_q;
  assign m_bucket_o = m_bucket_q;
  assign m_hash_o   = m_hash_q;

`ifndef SYNTHESIS
  // a line end with a nonzero divisor starts the remainder loop
  a_line_end_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && line_end && bucket_count_i != '0) |=> state_q == lkhp_pkg::ST_DIV)
    else $error("remainder loop not started after line end");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkhp_pkg::ST_DIV) |-> rem_q < bucket_count_i)
    else $error("partial remainder out of range");

  // a new result only comes from the output state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == lkhp_pkg::ST_OUT))
    else $error("result raised outside output state");

  // multiply step counter stays within the prime's terms
  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkhp_pkg::ST_MUL) |-> cnt_q < lkhp_pkg::CNT_W'(lkhp_pkg::MUL_STEPS))
    else $error("multiply step counter overrun");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/line_key_hash_partitioner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_key_hash_partitioner
// FNV-1a key hash and bucket index for each line of a key/value byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_t* carries one text byte per transfer; tlast flags the final byte of
//   the stream. Bytes of a line's key (up to the first tab or zero byte) are
//   folded into the hash; a newline or a tlast byte ends the line and
//   produces one result on m_t*: the key hash and hash modulo bucket_count.
//   The APB port holds bucket_count at address 0 (reset 1); write it while
//   the block is idle. A count of zero gives bucket 0.
// Timing:
//   key byte: the transfer, then five add steps of the shared adder.
//   other non-ending byte: the transfer alone.
//   line end: the transfer, then 32 restoring remainder steps on the same
//   adder and the result load, or the load alone when bucket_count is zero;
//   the next byte can be taken in the cycle after the result is loaded.
//   s_tready is high only while the sequencer is idle.
// Reset and stall:
//   reset puts the hash at the offset basis and the key phase on. A stalled
//   result stays in the output register; the next line end waits for it to
//   drain, while bytes within a line keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module line_key_hash_partitioner (
  input  logic         clk_i,
  input  logic         rst_ni,
  // apb configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,  // [7:0] data_byte
  input  logic         s_tlast_i,  // stream_end
  // result stream
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [47:0]  m_tdata_o   // [15:0] bucket, [47:16] key_hash
);

  logic [lkhp_pkg::BKT_W-1:0]  bucket_count_q;
  logic [lkhp_pkg::BKT_W-1:0]  bucket;
  logic [lkhp_pkg::HASH_W-1:0] key_hash;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[2] == lkhp_pkg::REG_BUCKET_COUNT);

  // bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= lkhp_pkg::BKT_W'(1);
    end else if (wr_en) begin
      bucket_count_q <= pwdata[lkhp_pkg::BKT_W-1:0];
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == lkhp_pkg::REG_BUCKET_COUNT) begin
      prdata = {{(32 - lkhp_pkg::BKT_W){1'b0}}, bucket_count_q};
    end else begin
      prdata = '0;
    end
  end

  lkhp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .s_tvalid_i     (s_tvalid_i),
    .s_tready_o     (s_tready_o),
    .s_tdata_i      (s_tdata_i),
    .s_tlast_i      (s_tlast_i),
    .m_tvalid_o     (m_tvalid_o),
    .m_tready_i     (m_tready_i),
    .m_bucket_o     (bucket),
    .m_hash_o       (key_hash)
  );

  assign m_tdata_o = {key_hash, bucket};

endmodule

`default_nettype wire

// ----- tb/tb_line_key_hash_partitioner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_key_hash_partitioner
// Self-checking bench for the per-line FNV-1a key hash and bucket partitioner.
// A small scoreboard class tracks the running hash, the key phase and the
// bucket divisor. It queues one expected result per line end and compares
// every result transfer field by field. Directed lines cover empty keys, tab
// and zero separators, extreme bytes and stream ends. Random well-formed
// lines with some noise then run under several bucket counts, including
// 0, 1 and 65535, with random idling on both sides and one long result
// hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_key_hash_partitioner;

  localparam logic [lkhp_pkg::HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [2:0]  ADDR_BUCKET  = {lkhp_pkg::REG_BUCKET_COUNT, 2'b00};
  localparam logic [2:0]  ADDR_UNUSED  = 3'd4;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned NUM_PHASES   = 8;

  typedef struct packed {
    logic [lkhp_pkg::HASH_W-1:0] key_hash;
    logic [lkhp_pkg::BKT_W-1:0]  bucket;
  } line_result_t;

  // running line hash and the queue of expected line results
  class line_hash_board;
    line_result_t                expected_lines[$];
    logic [lkhp_pkg::HASH_W-1:0] hash_acc;
    bit                          in_key;
    logic [lkhp_pkg::BKT_W-1:0]  bucket_div;
    int unsigned                 errors;
    int unsigned                 lines_checked;

    function new();
      hash_acc      = lkhp_pkg::FNV_BASIS;
      in_key        = 1'b1;
      bucket_div    = 16'd1;
      errors        = 0;
      lines_checked = 0;
    endfunction

    function void set_bucket_count(logic [lkhp_pkg::BKT_W-1:0] value);
      bucket_div = value;
    endfunction

    function void note_byte(logic [lkhp_pkg::BYTE_W-1:0] b, logic last);
      line_result_t r;
      if (last || b == lkhp_pkg::BYTE_NEWLINE) begin
        r.key_hash = hash_acc;
        r.bucket   = (bucket_div == '0) ? '0 :
                     lkhp_pkg::BKT_W'(hash_acc % {16'd0, bucket_div});
        expected_lines.push_back(r);
        hash_acc = lkhp_pkg::FNV_BASIS;
        in_key   = 1'b1;
      end else if (in_key) begin
        if (b == lkhp_pkg::BYTE_TAB || b == lkhp_pkg::BYTE_NUL) begin
          in_key = 1'b0;
        end else begin
          hash_acc = (hash_acc ^ {24'd0, b}) * FNV_PRIME;
        end
      end
    endfunction

    function void check_result(logic [47:0] tdata);
      line_result_t got;
      line_result_t want;
      got = tdata;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, hash %h bucket %0d", $time,
                 got.key_hash, got.bucket);
      end else begin
        want = expected_lines.pop_front();
        lines_checked++;
        if (got.key_hash !== want.key_hash) begin
          errors++;
          $display("%0t: key_hash mismatch, expected %h actual %h", $time,
                   want.key_hash, got.key_hash);
        end
        if (got.bucket !== want.bucket) begin
          errors++;
          $display("%0t: bucket mismatch, expected %0d actual %0d", $time,
                   want.bucket, got.bucket);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;  // [7:0] data_byte
  logic        s_tlast_i;  // stream_end
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [47:0] m_tdata_o;  // [15:0] bucket, [47:16] key_hash

  line_hash_board board;
  int unsigned    bytes_sent;
  int unsigned    cycle_count;
  int unsigned    hold_left;
  int unsigned    stall_left;
  bit             hold_req;
  bit             quiet;
  bit             tx_gaps;

  line_key_hash_partitioner u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_line_key_hash_partitioner: done, errors");
      $finish;
    end
  end

  // result sink: long hold-off on request, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYC;
    end
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      board.check_result(m_tdata_o);
    end
  end

  // one byte transfer, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
    board.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every line result has come back and the block settles
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (board.expected_lines.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_BUCKET) board.set_bucket_count(value[15:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // read back the bucket count and compare
  task automatic apb_check_bucket();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_BUCKET;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'd0, board.bucket_div}) begin
      board.errors++;
      $display("%0t: bucket_count read mismatch, expected %0d actual %0d", $time,
               board.bucket_div, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] key_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == lkhp_pkg::BYTE_TAB || b == lkhp_pkg::BYTE_NEWLINE);
    return b;
  endfunction

  // one random line: mostly key, separator, value, newline; sometimes noise
  task automatic send_line();
    int unsigned n;
    logic [7:0]  b;
    tx_gaps = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 15) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom), ($urandom_range(0, 15) == 0));
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) send_byte(key_byte(), 1'b0);
      if ($urandom_range(0, 3) != 0) begin
        send_byte(($urandom_range(0, 4) == 0) ? lkhp_pkg::BYTE_NUL :
                  lkhp_pkg::BYTE_TAB, 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) begin
          do b = 8'($urandom); while (b == lkhp_pkg::BYTE_NEWLINE);
          send_byte(b, 1'b0);
        end
      end
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b1);
      else send_byte(lkhp_pkg::BYTE_NEWLINE, 1'b0);
    end
  endtask

  // main sequence
  initial begin
    logic [8:0]  directed[];
    logic [15:0] setting;
    int unsigned phase_start;

    board      = new();
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    s_tlast_i  = 1'b0;
    m_tready_i = 1'b0;
    hold_req   = 1'b0;
    quiet      = 1'b0;
    tx_gaps    = 1'b1;
    hold_left  = 0;
    stall_left = 0;
    bytes_sent = 0;
    cycle_count = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines under the reset bucket count
    directed = '{
      {1'b0, lkhp_pkg::BYTE_NEWLINE},                         // empty key
      {1'b0, lkhp_pkg::BYTE_TAB}, {1'b0, 8'h41},              // key ends at once
      {1'b0, lkhp_pkg::BYTE_NEWLINE},
      {1'b0, lkhp_pkg::BYTE_NUL},                             // zero ends key
      {1'b0, lkhp_pkg::BYTE_NEWLINE},
      {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, 8'h01}, {1'b0, 8'h7F},
      {1'b0, lkhp_pkg::BYTE_TAB}, {1'b0, 8'hFF},              // ignored tail
      {1'b0, lkhp_pkg::BYTE_NUL},
      {1'b0, lkhp_pkg::BYTE_NEWLINE},
      {1'b0, 8'h61}, {1'b1, lkhp_pkg::BYTE_NEWLINE},          // newline at end
      {1'b0, 8'h62}, {1'b1, 8'h55},                           // end byte unhashed
      {1'b1, lkhp_pkg::BYTE_TAB}, {1'b1, lkhp_pkg::BYTE_NUL}
    };
    apb_check_bucket();
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    // an unknown register write must leave the bucket count alone
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    apb_check_bucket();

    // random phases under several bucket counts
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       setting = 16'd65535;
        1:       setting = 16'd0;
        2:       setting = 16'd1;
        3:       setting = 16'd2;
        4, 6:    setting = 16'($urandom_range(3, 64));
        default: setting = 16'($urandom_range(1, 65535));
      endcase
      drain();
      apb_write(ADDR_BUCKET, {16'($urandom), setting});
      apb_check_bucket();
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      if (p == 3) hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) send_line();
    end

    // close the last line and wait for the tail
    send_byte(lkhp_pkg::BYTE_NEWLINE, 1'b1);
    s_tvalid_i <= 1'b0;
    while (board.expected_lines.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);

    $display("sent %0d bytes, checked %0d line results over %0d bucket settings",
             bytes_sent, board.lines_checked, NUM_PHASES + 1);
    $display("with empty keys, tab and zero separators, stream ends and a long hold-off");
    if (board.errors == 0) begin
      $display("tb_line_key_hash_partitioner: done, clean");
    end else begin
      $display("tb_line_key_hash_partitioner: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
